FILE: rtl/core/ppr_pkg.sv
// Shared types and constants of the partition product refiner.
package ppr_pkg;

   localparam int MAX_LEAVES = 64;
   localparam int LABEL_W    = 7;
   localparam int COUNT_W    = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 64;

   localparam logic [LABEL_W-1:0] LABEL_ZERO = '0;
   localparam logic [LABEL_W-1:0] LABEL_ONE  = LABEL_W'(1);
   localparam logic [COUNT_W-1:0] PART_SAT   = '1;

   localparam logic FUNC_REFINE = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_LEAF_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SET   = CSR_IDX_W'(1);

   typedef logic [MAX_LEAVES-1:0]              leaf_vec_type;
   typedef logic [MAX_LEAVES-1:0][LABEL_W-1:0] label_row_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_PICK  = 3'b010,
      ST_APPLY = 3'b100
   } state_type;

   // broadcast from the sequencer to every lane
   typedef struct packed {
      logic               init;
      logic               apply;
      logic               cur_second;
      logic [LABEL_W-1:0] code;
      logic [LABEL_W-1:0] label;
      logic [LABEL_W-1:0] query_idx;
   } lane_cmd_type;

   typedef struct packed {
      logic apply_hit;
      logic query_hit;
   } lane_stat_type;

endpackage

FILE: rtl/core/partition_product_refiner_top.sv
// Top level: sequencer, leaf lanes, merge stage and result register.
//
// A query's result strobes on rsp_valid in the cycle after start is taken.
// A refine iterates over the new parts it opens (at most one per leaf);
// each part goes through a pick step in the merge stage (lowest remaining
// leaf and its previous label) and an apply step in which all lanes compare
// and relabel at once. A refine whose leaf set misses the base set answers
// in the cycle after start is taken. busy is high while a refine iterates;
// the result is held for exactly one cycle and the receiver cannot stall it.
// Configuration writes are taken (csr_ready is always high) and must only be
// issued while idle.
module partition_product_refiner_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic                                req_new_product,
   input  logic [ppr_pkg::MAX_LEAVES-1:0]      req_leaf_set,
   input  logic [ppr_pkg::LABEL_W-1:0]         req_part_index,
   output logic                                rsp_valid,
   output logic [ppr_pkg::COUNT_W-1:0]         rsp_part_count,
   output logic                                rsp_part_found,
   output logic [ppr_pkg::MAX_LEAVES-1:0]      rsp_part_members,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ppr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ppr_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ppr_pkg::*;

   state_type          state_ff, state_in;
   logic [6:0]         leaf_count_ff, leaf_count_in;
   leaf_vec_type       base_ff, base_in;
   leaf_vec_type       rem_ff, rem_in;
   logic               cur_second_ff, cur_second_in;
   logic [COUNT_W-1:0] parts_ff, parts_in;
   logic [LABEL_W-1:0] code_ff, code_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_found_ff, rsp_found_in;
   leaf_vec_type       rsp_members_ff, rsp_members_in;

   lane_cmd_type       cmd;
   leaf_vec_type       in_use;
   leaf_vec_type       members_init;
   leaf_vec_type       apply_hits;
   leaf_vec_type       query_hits;
   label_row_type      prev_labels;
   logic [LABEL_W-1:0] merged_code;
   logic               accept;
   logic               csr_write;
   logic               base_write;
   logic               query_found;
   logic [COUNT_W-1:0] parts_inc;

   assign accept     = start && !busy;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign base_write = csr_write && (csr_index == CSR_BASE_SET);

   assign members_init = leaf_vec_type'(csr_wdata) & in_use;
   assign query_found  = (req_part_index != LABEL_ZERO) && (req_part_index <= parts_ff);
   assign parts_inc    = (parts_ff == PART_SAT) ? parts_ff : parts_ff + COUNT_W'(1);

   assign cmd.init       = base_write;
   assign cmd.apply      = (state_ff == ST_APPLY);
   assign cmd.cur_second = cur_second_ff;
   assign cmd.code       = code_ff;
   assign cmd.label      = parts_ff;
   assign cmd.query_idx  = req_part_index;

   for (genvar k = 0; k < MAX_LEAVES; k++) begin : g_lane
      lane_stat_type stat;

      // leaf counts above the lane count cover every lane
      assign in_use[k] = (7'(k) < leaf_count_ff);

      ppr_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .in_use     (in_use[k]),
         .member     (members_init[k]),
         .remaining  (rem_ff[k]),
         .prev_label (prev_labels[k]),
         .stat       (stat)
      );

      assign apply_hits[k] = stat.apply_hit;
      assign query_hits[k] = stat.query_hit;
   end

   ppr_merge u_merge (
      .remaining   (rem_ff),
      .prev_labels (prev_labels),
      .code        (merged_code)
   );

   always_comb begin
      state_in       = state_ff;
      leaf_count_in  = leaf_count_ff;
      base_in        = base_ff;
      rem_in         = rem_ff;
      cur_second_in  = cur_second_ff;
      parts_in       = parts_ff;
      code_in        = code_ff;
      rsp_valid_in   = 1'b0;
      rsp_count_in   = rsp_count_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_members_in = rsp_members_ff;

      if (csr_write) begin
         unique case (csr_index)
            CSR_LEAF_COUNT: leaf_count_in = csr_wdata[6:0];
            CSR_BASE_SET: begin
               base_in       = leaf_vec_type'(csr_wdata);
               cur_second_in = 1'b0;
               parts_in      = (members_init != '0) ? COUNT_W'(1) : COUNT_W'(0);
            end
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_QUERY) begin
                  rsp_valid_in   = 1'b1;
                  rsp_count_in   = parts_ff;
                  rsp_found_in   = query_found;
                  rsp_members_in = query_found ? query_hits : '0;
               end else begin
                  if (req_new_product) begin
                     parts_in      = '0;
                     cur_second_in = !cur_second_ff;
                  end
                  rem_in = req_leaf_set & base_ff & in_use;
                  if (rem_in == '0) begin
                     rsp_valid_in   = 1'b1;
                     rsp_count_in   = parts_in;
                     rsp_found_in   = 1'b0;
                     rsp_members_in = '0;
                  end else begin
                     state_in = ST_PICK;
                  end
               end
            end
         end
         ST_PICK: begin
            code_in  = merged_code;
            parts_in = parts_inc;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            rem_in = rem_ff & ~apply_hits;
            if (rem_in == '0) begin
               rsp_valid_in   = 1'b1;
               rsp_count_in   = parts_ff;
               rsp_found_in   = 1'b0;
               rsp_members_in = '0;
               state_in       = ST_IDLE;
            end else begin
               state_in = ST_PICK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         leaf_count_ff <= 7'(MAX_LEAVES);
         base_ff       <= '0;
         rem_ff        <= '0;
         cur_second_ff <= 1'b0;
         parts_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         leaf_count_ff <= leaf_count_in;
         base_ff       <= base_in;
         rem_ff        <= rem_in;
         cur_second_ff <= cur_second_in;
         parts_ff      <= parts_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff        <= code_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_members_ff <= rsp_members_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_part_count   = rsp_count_ff;
   assign rsp_part_found   = rsp_found_ff;
   assign rsp_part_members = rsp_members_ff;

endmodule

FILE: rtl/core/ppr_lane.sv
// One leaf: its two labels, the refine match and the query match.
module ppr_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  ppr_pkg::lane_cmd_type cmd,
   input  logic                  in_use,
   input  logic                  member,
   input  logic                  remaining,
   output logic [ppr_pkg::LABEL_W-1:0] prev_label,
   output ppr_pkg::lane_stat_type      stat
);
   import ppr_pkg::*;

   logic [LABEL_W-1:0] first_ff,  first_in;
   logic [LABEL_W-1:0] second_ff, second_in;
   logic [LABEL_W-1:0] cur_label;

   assign cur_label  = cmd.cur_second ? second_ff : first_ff;
   assign prev_label = cmd.cur_second ? first_ff  : second_ff;

   assign stat.apply_hit = remaining && (prev_label == cmd.code);
   assign stat.query_hit = in_use && (cur_label == cmd.query_idx);

   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      if (cmd.init) begin
         first_in  = member ? LABEL_ONE : LABEL_ZERO;
         second_in = LABEL_ZERO;
      end else if (cmd.apply && stat.apply_hit) begin
         if (cmd.cur_second) begin
            second_in = cmd.label;
         end else begin
            first_in = cmd.label;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= LABEL_ZERO;
         second_ff <= LABEL_ZERO;
      end else begin
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

endmodule

FILE: rtl/core/ppr_merge.sv
// Picks the lowest remaining leaf and returns its previous-row label.
module ppr_merge (
   input  ppr_pkg::leaf_vec_type         remaining,
   input  ppr_pkg::label_row_type        prev_labels,
   output logic [ppr_pkg::LABEL_W-1:0]   code
);
   import ppr_pkg::*;

   leaf_vec_type lowest;

   // two's complement trick isolates the lowest set bit
   assign lowest = remaining & (~remaining + leaf_vec_type'(1));

   always_comb begin
      code = LABEL_ZERO;
      for (int k = 0; k < MAX_LEAVES; k++) begin
         code = code | (prev_labels[k] & {LABEL_W{lowest[k]}});
      end
   end

endmodule

FILE: rtl/core/ppr_checker.sv
// Port-level checks of the refiner, bound to the top level.
module ppr_props (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic [ppr_pkg::COUNT_W-1:0]     rsp_part_count,
   input logic                            rsp_part_found,
   input logic [ppr_pkg::MAX_LEAVES-1:0]  rsp_part_members
);
   import ppr_pkg::*;

   // a beat never shows while a refine still iterates
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while busy");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted item neither worked on nor answered");

   a_miss_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_part_found) |-> (rsp_part_members == '0))
      else $error("members reported for a part not found");

   a_found_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_part_found) |-> (rsp_part_count != '0))
      else $error("part found with zero part count");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("activity right after reset");

endmodule

bind partition_product_refiner_top ppr_props u_ppr_props (.*);
